>>> sv/chuff_pkg.sv
`timescale 1ns / 1ps

package chuff_pkg;

  localparam int SYM_W  = 8;
  localparam int LEN_W  = 5;
  localparam int CODE_W = 16;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_ENCODE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_CNT_DRAIN,
    ST_STEP,
    ST_ASSIGN,
    ST_ASN_DRAIN
  } state_t;

endpackage

>>> sv/chuff_ram.sv
`timescale 1ns / 1ps

module chuff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/canonical_huffman_encoder.sv
`timescale 1ns / 1ps

// Canonical Huffman code table with lookup.
// An item is taken when start is high and busy is low. A load item
// (in_action low) writes the code length of in_symbol; a length of zero marks
// the symbol absent. A load item with in_load_last set starts the code
// assignment, which holds busy high through one pass over the length memory
// to count symbols per length, one step per length to form the first code
// of each length, and a second pass over the length memory that writes
// the code memory.
// An encode item (in_action high) gives one result with out_strobe high in
// the cycle after it is taken, set by the registered read of the two
// memories. Load items without the last mark and encode items are taken one
// per cycle. An encode before any assignment, or after a later load, answers
// zeros. The receiver cannot stall: each result is shown for one cycle.
// After reset the length memory is cleared one entry per cycle, and busy stays
// high until every entry is cleared, before the first item is taken.
module canonical_huffman_encoder #(
  parameter int NUM_SYMBOLS  = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic [chuff_pkg::SYM_W-1:0]  in_symbol,
  input  logic [chuff_pkg::LEN_W-1:0]  in_length_in,
  input  logic                         in_load_last,
  output logic                         out_strobe,
  output logic [chuff_pkg::CODE_W-1:0] out_code,
  output logic [chuff_pkg::LEN_W-1:0]  out_code_length,
  output logic                         out_present
);

  localparam int AW    = $clog2(NUM_SYMBOLS);
  localparam int NSLOT = MAX_CODE_LEN;
  localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  chuff_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] ctr_r, ctr_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic          proc_cnt_r, proc_asn_r;
  logic [AW-1:0] paddr_r;
  logic          enc_r, enc_ok_r;
  logic          table_ready_r, table_ready_nxt;

  // Holds symbols per length during counting, then the next code per length.
  logic [chuff_pkg::CODE_W-1:0] ncode_r [NSLOT];
  logic [chuff_pkg::CODE_W-1:0] ncode_nxt [NSLOT];
  logic [chuff_pkg::CODE_W-1:0] acc_r, acc_nxt;
  logic [chuff_pkg::CODE_W-1:0] tprev_r, tprev_nxt;

  logic                         accept, is_load, is_enc, sym_ok;
  logic [chuff_pkg::LEN_W-1:0]  len_clamp;
  logic                         ctr_last, slot_last;
  logic                         issue_cnt, issue_asn;

  logic                         len_we;
  logic [AW-1:0]                len_waddr, len_raddr;
  logic [chuff_pkg::LEN_W-1:0]  len_wdata, len_rd;
  logic                         code_we;
  logic [chuff_pkg::CODE_W-1:0] code_wdata, code_rd;

  logic [chuff_pkg::LEN_W-1:0]  len_m1;
  logic [SW-1:0]                len_slot;
  logic [chuff_pkg::CODE_W-1:0] code_mask, step_sum, step_val;
  logic                         hit;

  assign accept  = start & ~busy;
  assign is_load = accept & (in_action == chuff_pkg::ACT_LOAD);
  assign is_enc  = accept & (in_action == chuff_pkg::ACT_ENCODE);
  assign sym_ok  = {1'b0, in_symbol} < (chuff_pkg::SYM_W + 1)'(NUM_SYMBOLS);

  assign len_clamp = (32'(in_length_in) > 32'(MAX_CODE_LEN)) ?
                     chuff_pkg::LEN_W'(MAX_CODE_LEN) : in_length_in;

  assign ctr_last  = (ctr_r == AW'(NUM_SYMBOLS - 1));
  assign slot_last = (slot_r == SW'(NSLOT - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chuff_pkg::ST_CLEAR: begin
        if (ctr_last) state_nxt = chuff_pkg::ST_IDLE;
      end
      chuff_pkg::ST_IDLE: begin
        if (is_load && in_load_last) state_nxt = chuff_pkg::ST_COUNT;
      end
      chuff_pkg::ST_COUNT: begin
        if (ctr_last) state_nxt = chuff_pkg::ST_CNT_DRAIN;
      end
      chuff_pkg::ST_CNT_DRAIN: begin
        state_nxt = chuff_pkg::ST_STEP;
      end
      chuff_pkg::ST_STEP: begin
        if (slot_last) state_nxt = chuff_pkg::ST_ASSIGN;
      end
      chuff_pkg::ST_ASSIGN: begin
        if (ctr_last) state_nxt = chuff_pkg::ST_ASN_DRAIN;
      end
      chuff_pkg::ST_ASN_DRAIN: begin
        state_nxt = chuff_pkg::ST_IDLE;
      end
      default: state_nxt = chuff_pkg::ST_IDLE;
    endcase
  end

  // State outputs: memory ports and pass control.
  always_comb begin
    busy      = 1'b1;
    len_we    = 1'b0;
    len_waddr = ctr_r;
    len_wdata = '0;
    len_raddr = ctr_r;
    issue_cnt = 1'b0;
    issue_asn = 1'b0;
    ctr_nxt   = ctr_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      chuff_pkg::ST_CLEAR: begin
        len_we  = 1'b1;
        ctr_nxt = ctr_last ? '0 : ctr_r + AW'(1);
      end
      chuff_pkg::ST_IDLE: begin
        busy      = 1'b0;
        len_we    = is_load & sym_ok;
        len_waddr = in_symbol[AW-1:0];
        len_wdata = len_clamp;
        len_raddr = in_symbol[AW-1:0];
      end
      chuff_pkg::ST_COUNT: begin
        issue_cnt = 1'b1;
        ctr_nxt   = ctr_last ? '0 : ctr_r + AW'(1);
      end
      chuff_pkg::ST_CNT_DRAIN: begin
        slot_nxt = '0;
      end
      chuff_pkg::ST_STEP: begin
        slot_nxt = slot_last ? '0 : slot_r + SW'(1);
      end
      chuff_pkg::ST_ASSIGN: begin
        issue_asn = 1'b1;
        ctr_nxt   = ctr_last ? '0 : ctr_r + AW'(1);
      end
      chuff_pkg::ST_ASN_DRAIN: begin
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  // A length of L lives in slot L-1; stored lengths never exceed MAX_CODE_LEN.
  assign len_m1    = len_rd - chuff_pkg::LEN_W'(1);
  assign len_slot  = len_m1[SW-1:0];
  assign code_mask = (len_rd >= chuff_pkg::LEN_W'(chuff_pkg::CODE_W)) ? '1 :
                     chuff_pkg::CODE_W'((17'd1 << len_rd) - 17'd1);
  assign step_sum  = acc_r + tprev_r;
  assign step_val  = (slot_r == '0) ? '0 : {step_sum[chuff_pkg::CODE_W-2:0], 1'b0};

  assign code_we    = proc_asn_r;
  assign code_wdata = (len_rd != '0) ? (ncode_r[len_slot] & code_mask) : '0;

  always_comb begin
    ncode_nxt = ncode_r;
    acc_nxt   = acc_r;
    tprev_nxt = tprev_r;
    if (is_load && in_load_last) begin
      for (int i = 0; i < NSLOT; i++) begin
        ncode_nxt[i] = '0;
      end
    end
    if ((proc_cnt_r || proc_asn_r) && (len_rd != '0)) begin
      ncode_nxt[len_slot] = ncode_r[len_slot] + chuff_pkg::CODE_W'(1);
    end
    if (state_r == chuff_pkg::ST_STEP) begin
      // Slot k turns from the count of length k+1 into its first code.
      ncode_nxt[slot_r] = step_val;
      acc_nxt           = step_val;
      tprev_nxt         = ncode_r[slot_r];
    end
  end

  always_comb begin
    table_ready_nxt = table_ready_r;
    if (is_load) begin
      table_ready_nxt = 1'b0;
    end else if (state_r == chuff_pkg::ST_ASN_DRAIN) begin
      table_ready_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= chuff_pkg::ST_CLEAR;
      ctr_r         <= '0;
      slot_r        <= '0;
      proc_cnt_r    <= 1'b0;
      proc_asn_r    <= 1'b0;
      enc_r         <= 1'b0;
      enc_ok_r      <= 1'b0;
      table_ready_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ctr_r         <= ctr_nxt;
      slot_r        <= slot_nxt;
      proc_cnt_r    <= issue_cnt;
      proc_asn_r    <= issue_asn;
      enc_r         <= is_enc;
      enc_ok_r      <= is_enc & table_ready_r & sym_ok;
      table_ready_r <= table_ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    paddr_r <= ctr_r;
    ncode_r <= ncode_nxt;
    acc_r   <= acc_nxt;
    tprev_r <= tprev_nxt;
  end

  chuff_ram #(
    .WIDTH (chuff_pkg::LEN_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .raddr (len_raddr),
    .rdata (len_rd)
  );

  chuff_ram #(
    .WIDTH (chuff_pkg::CODE_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (paddr_r),
    .wdata (code_wdata),
    .raddr (in_symbol[AW-1:0]),
    .rdata (code_rd)
  );

  assign hit             = enc_ok_r & (len_rd != '0);
  assign out_strobe      = enc_r;
  assign out_code        = hit ? code_rd : '0;
  assign out_code_length = hit ? len_rd : '0;
  assign out_present     = hit;

endmodule

>>> verif/canonical_huffman_encoder_tb.sv
`timescale 1ns / 1ps

module canonical_huffman_encoder_tb;
  import chuff_pkg::*;

  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 16;
  localparam int ITEM_TARGET  = 520;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  code_length;
    logic              present;
  } code_word_t;

  // Tracks the length table and the canonical codes built from it, and holds
  // the code words that encode items are still owed.
  class code_table_scoreboard;
    bit [LEN_W-1:0]  lengths [NUM_SYMBOLS];
    bit [CODE_W-1:0] codes [NUM_SYMBOLS];
    bit              table_ready;
    code_word_t      owed_words [$];
    int              errors;

    function new();
      table_ready = 1'b0;
      errors      = 0;
    endfunction

    function void build_codes();
      int unsigned     tally [MAX_CODE_LEN+1];
      longint unsigned next_code [MAX_CODE_LEN+1];
      longint unsigned acc;
      longint unsigned mask;
      int unsigned     l;
      foreach (tally[i]) tally[i] = 0;
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        l = lengths[s];
        if (l != 0) tally[l]++;
      end
      acc = 0;
      next_code[0] = 0;
      for (int n = 1; n <= MAX_CODE_LEN; n++) begin
        acc = (acc + tally[n-1]) << 1;
        if (n == 1) acc = 0;
        next_code[n] = acc;
      end
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        l = lengths[s];
        if (l != 0) begin
          mask = (64'd1 << l) - 64'd1;
          codes[s] = CODE_W'(next_code[l] & mask);
          next_code[l]++;
        end else begin
          codes[s] = '0;
        end
      end
      table_ready = 1'b1;
    endfunction

    function void note_item(logic act, logic [SYM_W-1:0] sym, logic [LEN_W-1:0] len,
                            logic last);
      code_word_t w;
      if (act == ACT_LOAD) begin
        // Lengths beyond the longest code are clamped to it.
        lengths[sym] = (len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : len;
        table_ready  = 1'b0;
        if (last) build_codes();
      end else begin
        w = '0;
        if (table_ready && lengths[sym] != 0) begin
          w.code        = codes[sym];
          w.code_length = lengths[sym];
          w.present     = 1'b1;
        end
        owed_words = {owed_words, w};
      end
    endfunction

    function void check_word(logic [CODE_W-1:0] code, logic [LEN_W-1:0] code_length,
                             logic present);
      code_word_t w;
      if (owed_words.size() == 0) begin
        $error("unexpected result: code %h code_length %0d present %b",
               code, code_length, present);
        errors++;
        return;
      end
      w = owed_words.pop_front();
      if (code !== w.code) begin
        $error("code: expected %h, actual %h", w.code, code);
        errors++;
      end
      if (code_length !== w.code_length) begin
        $error("code_length: expected %0d, actual %0d", w.code_length, code_length);
        errors++;
      end
      if (present !== w.present) begin
        $error("present: expected %b, actual %b", w.present, present);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_action = ACT_LOAD;
  logic [SYM_W-1:0]  in_symbol = '0;
  logic [LEN_W-1:0]  in_length_in = '0;
  logic              in_load_last = 1'b0;
  logic              out_strobe;
  logic [CODE_W-1:0] out_code;
  logic [LEN_W-1:0]  out_code_length;
  logic              out_present;

  code_table_scoreboard sb = new();
  int                   items_sent = 0;
  int                   cycle_count = 0;

  canonical_huffman_encoder #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_symbol       (in_symbol),
    .in_length_in    (in_length_in),
    .in_load_last    (in_load_last),
    .out_strobe      (out_strobe),
    .out_code        (out_code),
    .out_code_length (out_code_length),
    .out_present     (out_present)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe === 1'b1) sb.check_word(out_code, out_code_length, out_present);
      if (start && busy === 1'b0) sb.note_item(in_action, in_symbol, in_length_in,
                                                in_load_last);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 92) return LEN_W'($urandom_range(1, MAX_CODE_LEN));
    return LEN_W'($urandom_range(MAX_CODE_LEN + 1, 31));
  endfunction

  // Holds the item until it is taken; start is only lowered when a gap follows.
  task automatic send_item(logic act, logic [SYM_W-1:0] sym, logic [LEN_W-1:0] len,
                           logic last, int gap);
    start        <= 1'b1;
    in_action    <= act;
    in_symbol    <= sym;
    in_length_in <= len;
    in_load_last <= last;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    logic [SYM_W-1:0] probe [$];
    probe = '{8'd0, 8'd255, 8'd128, 8'd7, 8'd3, 8'd4, 8'd1, 8'd200};
    send_item(ACT_LOAD, 8'd0, 5'd1, 1'b0, 0);
    send_item(ACT_LOAD, 8'd255, 5'd16, 1'b0, 1);
    send_item(ACT_LOAD, 8'd128, 5'd31, 1'b0, 0);
    send_item(ACT_LOAD, 8'd7, 5'd17, 1'b0, 2);
    send_item(ACT_LOAD, 8'd3, 5'd5, 1'b0, 0);
    send_item(ACT_LOAD, 8'd4, 5'd0, 1'b0, 0);
    send_item(ACT_LOAD, 8'd1, 5'd2, 1'b1, 0);
    foreach (probe[i]) send_item(ACT_ENCODE, probe[i], 5'd0, 1'b0, 0);
    // An encode item ignores the last mark.
    send_item(ACT_ENCODE, 8'd255, 5'd31, 1'b1, 1);
    // A load without the last mark leaves the table not ready.
    send_item(ACT_LOAD, 8'd9, 5'd3, 1'b0, 0);
    send_item(ACT_ENCODE, 8'd0, 5'd0, 1'b0, 0);
    send_item(ACT_ENCODE, 8'd9, 5'd0, 1'b0, 3);
    send_item(ACT_LOAD, 8'd9, 5'd3, 1'b1, 0);
    send_item(ACT_ENCODE, 8'd9, 5'd0, 1'b0, 0);
    send_item(ACT_ENCODE, 8'd0, 5'd0, 1'b0, 0);
  endtask

  task automatic run_table_batch();
    logic [SYM_W-1:0] loaded [$];
    logic [SYM_W-1:0] sym;
    bit               quiet;
    int               n_loads;
    int               n_encodes;
    quiet     = ($urandom_range(0, 3) == 0);
    n_loads   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    n_encodes = $urandom_range(2, 20);
    for (int i = 0; i < n_loads; i++) begin
      sym = SYM_W'($urandom_range(0, 255));
      loaded = {loaded, sym};
      send_item(ACT_LOAD, sym, pick_length(), i == n_loads - 1, quiet ? 0 : pick_gap());
    end
    for (int i = 0; i < n_encodes; i++) begin
      if ($urandom_range(0, 9) < 7) sym = loaded[$urandom_range(0, loaded.size() - 1)];
      else sym = SYM_W'($urandom_range(0, 255));
      send_item(ACT_ENCODE, sym, LEN_W'($urandom_range(0, 31)), 1'(($urandom_range(0, 1))),
                quiet ? 0 : pick_gap());
    end
  endtask

  task automatic run_noise_batch(bit allow_last);
    logic act;
    logic last;
    int   n;
    n = $urandom_range(3, 15);
    for (int i = 0; i < n; i++) begin
      act  = 1'($urandom_range(0, 1));
      last = (act == ACT_ENCODE) ? 1'($urandom_range(0, 1))
                                 : (allow_last && $urandom_range(0, 7) == 0);
      send_item(act, SYM_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 31)), last,
                pick_gap());
    end
  endtask

  initial begin
    int mode;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    while (items_sent < ITEM_TARGET) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) run_table_batch();
      else if (mode < 9) run_noise_batch(1'b1);
      else run_noise_batch(1'b0);
    end
    start <= 1'b0;
    while (sb.owed_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
sv/chuff_pkg.sv
sv/chuff_ram.sv
sv/canonical_huffman_encoder.sv
verif/canonical_huffman_encoder_tb.sv
